### hw/rtl/lsra_pkg.sv
package lsra_pkg;

	localparam int ID_W     = 32;
	localparam int PLACE_W  = 16;
	localparam int COLOR_W  = 6;
	localparam int TOTAL_W  = 16;
	localparam int BUDGET_W = 6;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 6'd32;
	localparam logic [TOTAL_W-1:0]  SLOT_MAX     = '1;

	typedef struct packed {
		logic [ID_W-1:0]    resource;
		logic               spill;
		logic [PLACE_W-1:0] place;
		logic [COLOR_W-1:0] colors;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} result_t;

endpackage

### hw/rtl/lsra_out_reg.sv
module lsra_out_reg
	import lsra_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    free,
	output logic    valid,
	input  logic    stall,
	output result_t data
);

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

### hw/rtl/linear_scan_register_allocator.sv
// Linear-scan register allocator.
// Input channel (in_valid / in_stall): one live interval per item, sorted by start
// then end; first_of_set clears all allocation state before the item is handled.
// Output channel (out_valid / out_stall): one result per item, or two when an
// active interval is evicted (the victim's spill first, then the new interval).
// Config channel (cfg_valid / cfg_ready): register_budget, always ready, write it
// only while the block is idle.
// Steps per item: accept, an expiry scan over the busy registers in activation
// order (nothing to scan after first_of_set), a search upward from register 0 for
// the lowest free register below the budget limit, then loading of the result
// (or of both results). An eviction adds, before the result load, a shift that
// closes up the activation-order list behind the victim's position.
// The expiry scan walks the activation-order list memory and the entry memory
// through a two-read pipeline; the free search tests one busy bit per cycle.
// One item is in work at a time; in_stall is high from accept until the last
// result is loaded into the output register. A stalled output holds its item
// and the block waits before loading the next result.
// Reset empties the allocator and sets register_budget to 32; no clearing pass.
module linear_scan_register_allocator
	import lsra_pkg::*;
#(
	parameter int MAX_REGS   = 32,
	parameter int STEP_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [BUDGET_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                first_of_set,
	input  logic [31:0]         resource_id,
	input  logic [15:0]         from_step,
	input  logic [15:0]         to_step,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         out_resource,
	output logic                is_spill,
	output logic [15:0]         place_index,
	output logic [5:0]          color_count,
	output logic [15:0]         spill_total,
	output logic                last
);

	localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int CNT_W = $clog2(MAX_REGS + 1);
	localparam int CMP_W = (CNT_W > BUDGET_W) ? CNT_W : BUDGET_W;
	localparam int ENT_W = STEP_WIDTH + ID_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FREE  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;
	localparam logic [2:0] S_OUT2  = 3'd5;

	logic [2:0]            state_q;
	logic [BUDGET_W-1:0]   budget_q;
	logic [MAX_REGS-1:0]   busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rd_q;
	logic [CNT_W-1:0]      wr_q;
	logic [CNT_W-1:0]      free_q;
	logic [CNT_W-1:0]      hw_q;
	logic [TOTAL_W-1:0]    spill_q;
	logic [ID_W-1:0]       owner_q;
	logic [STEP_WIDTH-1:0] start_q;
	logic [STEP_WIDTH-1:0] end_q;
	logic                  v_s1;
	logic                  v_s2;
	logic [IDX_W-1:0]      reg_s2;
	logic                  vic_found_q;
	logic [STEP_WIDTH-1:0] vic_end_q;
	logic [ID_W-1:0]       vic_owner_q;
	logic [IDX_W-1:0]      vic_reg_q;
	logic [CNT_W-1:0]      vic_pos_q;
	result_t               res0_q;
	result_t               res1_q;
	logic                  two_q;

	// activation-order list and per-register entry {end, owner}
	logic [IDX_W-1:0] ord_mem [MAX_REGS];
	logic [ENT_W-1:0] ent_mem [MAX_REGS];
	logic [IDX_W-1:0] ord_rd_q;
	logic [ENT_W-1:0] ent_rd_q;
	logic             ord_we;
	logic [IDX_W-1:0] ord_wa;
	logic [IDX_W-1:0] ord_wd;
	logic [IDX_W-1:0] ord_ra;
	logic             ent_we;
	logic [IDX_W-1:0] ent_wa;
	logic [ENT_W-1:0] ent_wd;

	logic [STEP_WIDTH-1:0] ent_end;
	logic [ID_W-1:0]       ent_owner;
	logic                  accept;
	logic [CMP_W-1:0]      limit;
	logic                  free_hit;
	logic [IDX_W-1:0]      free_idx;
	logic                  take_free;
	logic                  expire_s2;
	logic                  keep_s2;
	logic                  shift_wr;
	logic                  shift_fin;
	logic [IDX_W-1:0]      take_reg;
	logic [CMP_W-1:0]      take_p1;
	logic                  out_free;
	logic                  out_load;
	result_t               load_res;
	result_t               out_res;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;

	assign ent_end   = ent_rd_q[ENT_W-1 -: STEP_WIDTH];
	assign ent_owner = ent_rd_q[ID_W-1:0];

	assign limit    = (CMP_W'(budget_q) < CMP_W'(MAX_REGS)) ? CMP_W'(budget_q)
		: CMP_W'(MAX_REGS);
	assign free_hit  = CMP_W'(free_q) < limit;
	assign free_idx  = free_q[IDX_W-1:0];
	assign take_free = (state_q == S_FREE) && free_hit && !busy_q[free_idx];

	assign expire_s2 = (state_q == S_SCAN) && v_s2 && (ent_end < start_q);
	assign keep_s2   = (state_q == S_SCAN) && v_s2 && !(ent_end < start_q);
	assign shift_wr  = (state_q == S_SHIFT) && v_s1;
	assign shift_fin = (state_q == S_SHIFT) && !v_s1 && (rd_q >= cnt_q);

	assign take_reg = (state_q == S_FREE) ? free_idx : vic_reg_q;
	assign take_p1  = CMP_W'(take_reg) + CMP_W'(1);

	always_comb begin
		ord_we = 1'b0;
		ord_wa = wr_q[IDX_W-1:0];
		ord_wd = reg_s2;
		ord_ra = rd_q[IDX_W-1:0];
		ent_we = 1'b0;
		ent_wa = take_reg;
		ent_wd = {end_q, owner_q};
		if (keep_s2) begin
			ord_we = 1'b1;
		end else if (take_free) begin
			ord_we = 1'b1;
			ord_wa = cnt_q[IDX_W-1:0];
			ord_wd = free_idx;
			ent_we = 1'b1;
		end else if (shift_wr) begin
			ord_we = 1'b1;
			ord_wd = ord_rd_q;
		end else if (shift_fin) begin
			ord_we = 1'b1;
			ord_wd = vic_reg_q;
			ent_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
		ord_rd_q <= ord_mem[ord_ra];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		ent_rd_q <= ent_mem[ord_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg_valid) begin
			budget_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= '0;
			cnt_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			free_q      <= '0;
			hw_q        <= '0;
			spill_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			vic_found_q <= 1'b0;
			two_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_q        <= '0;
						wr_q        <= '0;
						v_s1        <= 1'b0;
						v_s2        <= 1'b0;
						vic_found_q <= 1'b0;
						if (first_of_set) begin
							busy_q  <= '0;
							cnt_q   <= '0;
							hw_q    <= '0;
							spill_q <= '0;
						end
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_q < cnt_q) begin
						v_s1 <= 1'b1;
						rd_q <= rd_q + CNT_W'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					v_s2 <= v_s1;
					if (expire_s2) begin
						busy_q[reg_s2] <= 1'b0;
					end
					if (keep_s2) begin
						wr_q <= wr_q + CNT_W'(1);
						// strict compare keeps the earliest activated on equal ends
						if (!vic_found_q || ent_end > vic_end_q) begin
							vic_found_q <= 1'b1;
						end
					end
					if ((rd_q >= cnt_q) && !v_s1 && !v_s2) begin
						cnt_q   <= wr_q;
						free_q  <= '0;
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (take_free) begin
						busy_q[free_idx] <= 1'b1;
						cnt_q            <= cnt_q + CNT_W'(1);
						if (take_p1 > CMP_W'(hw_q)) begin
							hw_q <= CNT_W'(take_p1);
						end
						two_q   <= 1'b0;
						state_q <= S_OUT;
					end else if (!free_hit) begin
						if (spill_q != SLOT_MAX) begin
							spill_q <= spill_q + TOTAL_W'(1);
						end
						if (vic_found_q && (vic_end_q > end_q)) begin
							two_q   <= 1'b1;
							rd_q    <= vic_pos_q + CNT_W'(1);
							wr_q    <= vic_pos_q;
							v_s1    <= 1'b0;
							state_q <= S_SHIFT;
						end else begin
							two_q   <= 1'b0;
							state_q <= S_OUT;
						end
					end else begin
						free_q <= free_q + CNT_W'(1);
					end
				end
				S_SHIFT: begin
					// close up the list behind the victim, then append the new owner
					if (rd_q < cnt_q) begin
						v_s1 <= 1'b1;
						rd_q <= rd_q + CNT_W'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (shift_wr) begin
						wr_q <= wr_q + CNT_W'(1);
					end
					if (shift_fin) begin
						if (take_p1 > CMP_W'(hw_q)) begin
							hw_q <= CNT_W'(take_p1);
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= two_q ? S_OUT2 : S_IDLE;
					end
				end
				S_OUT2: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item fields, pipeline payload, victim and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			owner_q <= resource_id;
			start_q <= STEP_WIDTH'(from_step);
			end_q   <= STEP_WIDTH'(to_step);
		end
		reg_s2 <= ord_rd_q;
		if (keep_s2 && (!vic_found_q || ent_end > vic_end_q)) begin
			vic_end_q   <= ent_end;
			vic_owner_q <= ent_owner;
			vic_reg_q   <= reg_s2;
			vic_pos_q   <= wr_q;
		end
		if (take_free) begin
			res0_q <= '{resource: owner_q, spill: 1'b0, place: PLACE_W'(free_idx),
				colors: '0, total: '0, last: 1'b1};
		end else if ((state_q == S_FREE) && !free_hit) begin
			if (vic_found_q && (vic_end_q > end_q)) begin
				res0_q <= '{resource: vic_owner_q, spill: 1'b1, place: PLACE_W'(spill_q),
					colors: '0, total: '0, last: 1'b0};
				res1_q <= '{resource: owner_q, spill: 1'b0, place: PLACE_W'(vic_reg_q),
					colors: '0, total: '0, last: 1'b1};
			end else begin
				res0_q <= '{resource: owner_q, spill: 1'b1, place: PLACE_W'(spill_q),
					colors: '0, total: '0, last: 1'b1};
			end
		end
	end

	assign out_load = ((state_q == S_OUT) || (state_q == S_OUT2)) && out_free;

	always_comb begin
		load_res        = (state_q == S_OUT2) ? res1_q : res0_q;
		load_res.colors = COLOR_W'(hw_q);
		load_res.total  = spill_q;
		load_res.last   = (state_q == S_OUT2) || !two_q;
	end

	lsra_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_load),
		.push_data (load_res),
		.free      (out_free),
		.valid     (out_valid),
		.stall     (out_stall),
		.data      (out_res)
	);

	assign out_resource = out_res.resource;
	assign is_spill     = out_res.spill;
	assign place_index  = out_res.place;
	assign color_count  = out_res.colors;
	assign spill_total  = out_res.total;
	assign last         = out_res.last;

`ifndef SYNTHESIS
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(busy_q) == int'(cnt_q)))
		else $error("busy bits and activation list count disagree");

	a_spill_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> (spill_q >= $past(spill_q)))
		else $error("spill counter went down within an item");

	a_shift_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (vic_found_q && (cnt_q != '0)))
		else $error("eviction without a victim");
`endif

endmodule
